>>> design/owik_pkg.sv
// ----------------------------------------------------------------------------
// owik_pkg
// Shared types, register indexes and the quarter-wave sine table generator
// for the omni wheel inverse kinematics block.
// ----------------------------------------------------------------------------
package owik_pkg;

   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CsrWheelOneAngle   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrWheelTwoAngle   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrWheelThreeAngle = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrWheelOneLever   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrWheelTwoLever   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrWheelThreeLever = 3'd5;

   localparam logic [15:0] WheelOneAngleReset   = 16'd36409;
   localparam logic [15:0] WheelTwoAngleReset   = 16'd61895;
   localparam logic [15:0] WheelThreeAngleReset = 16'd16384;
   localparam logic signed [15:0] WheelOneLeverReset   = -16'sd2024;
   localparam logic signed [15:0] WheelTwoLeverReset   = -16'sd2024;
   localparam logic signed [15:0] WheelThreeLeverReset = -16'sd1671;

   localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic load_s4;
   } owik_stage_type;

   // sin(pi/2 * i / 2^bits) in Q15, Taylor series to the 13th power in Q30
   function automatic logic [15:0] sine_entry(input logic [63:0] i, input int bits);
      logic [63:0] n;
      logic [63:0] idx;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic signed [63:0] sum;
      n = 64'd1 << bits;
      idx = (i > n) ? n : i;
      t = (PiHalfQ30 * idx + (n >> 1)) >> bits;
      t2 = (t * t) >> 30;
      term = t;
      sum = $signed(t);
      term = ((term * t2) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd110;
      sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd156;
      sum = sum + $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
         sum = 64'sd32768;
      end
      return sum[15:0];
   endfunction

endpackage

>>> design/owik_sine_rom.sv
// ----------------------------------------------------------------------------
// owik_sine_rom
// Quarter-wave sine table, Q15, two registered read ports.
// ----------------------------------------------------------------------------
module owik_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic [SINE_TABLE_BITS:0]   addr_a,
   input  logic [SINE_TABLE_BITS:0]   addr_b,
   output logic [15:0]                data_a,
   output logic [15:0]                data_b
);
   import owik_pkg::*;

   localparam int Depth = (1 << SINE_TABLE_BITS) + 1;

   logic [15:0] rom_mem [Depth];
   logic [15:0] data_a_ff;
   logic [15:0] data_b_ff;

   for (genvar g = 0; g < Depth; g++) begin : g_entry
      assign rom_mem[g] = sine_entry(64'(g), SINE_TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_a_ff <= rom_mem[addr_a];
         data_b_ff <= rom_mem[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

>>> design/owik_wheel_lane.sv
// ----------------------------------------------------------------------------
// owik_wheel_lane
// One wheel: phase lookup, table read, products, rounded sum.
// ----------------------------------------------------------------------------
module owik_wheel_lane #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                     clock,
   input  owik_pkg::owik_stage_type stage,
   input  logic signed [15:0]       x_speed,
   input  logic signed [15:0]       y_speed,
   input  logic signed [15:0]       turn_rate,
   input  logic [15:0]              heading,
   input  logic [15:0]              angle,
   input  logic signed [15:0]       lever,
   output logic signed [17:0]       drive
);
   import owik_pkg::*;

   localparam int TableN = 1 << SINE_TABLE_BITS;
   localparam int AddrWidth = SINE_TABLE_BITS + 1;

   logic [15:0]                  phase;
   logic [SINE_TABLE_BITS+1:0]   phase_top;
   logic [1:0]                   sin_quad;
   logic [1:0]                   cos_quad;
   logic [AddrWidth-1:0]         idx_ext;
   logic [AddrWidth-1:0]         mirror;
   logic [AddrWidth-1:0]         sin_addr_in;
   logic [AddrWidth-1:0]         cos_addr_in;

   logic signed [15:0]           x1_ff;
   logic signed [15:0]           y1_ff;
   logic signed [15:0]           r1_ff;
   logic signed [15:0]           lever1_ff;
   logic [AddrWidth-1:0]         sin_addr1_ff;
   logic [AddrWidth-1:0]         cos_addr1_ff;
   logic                         sin_neg1_ff;
   logic                         cos_neg1_ff;

   logic [15:0]                  sin_mag;
   logic [15:0]                  cos_mag;
   logic signed [15:0]           x2_ff;
   logic signed [15:0]           y2_ff;
   logic                         sin_neg2_ff;
   logic                         cos_neg2_ff;
   logic signed [31:0]           turn2_in;
   logic signed [31:0]           turn2_ff;

   logic signed [16:0]           sin_val;
   logic signed [16:0]           cos_val;
   logic signed [32:0]           xc3_in;
   logic signed [32:0]           ys3_in;
   logic signed [32:0]           xc3_ff;
   logic signed [32:0]           ys3_ff;
   logic signed [31:0]           turn3_ff;

   logic signed [34:0]           sum4;
   logic signed [17:0]           drive_in;
   logic signed [17:0]           drive_ff;

   always_comb begin
      phase = angle + heading;
      phase_top = phase[15 -: SINE_TABLE_BITS+2];
      sin_quad = phase_top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
      cos_quad = sin_quad + 2'd1;
      idx_ext = {1'b0, phase_top[SINE_TABLE_BITS-1:0]};
      mirror = AddrWidth'(TableN) - idx_ext;
      sin_addr_in = sin_quad[0] ? mirror : idx_ext;
      cos_addr_in = cos_quad[0] ? mirror : idx_ext;
   end

   always_ff @(posedge clock) begin
      if (stage.load_s1) begin
         x1_ff <= x_speed;
         y1_ff <= y_speed;
         r1_ff <= turn_rate;
         lever1_ff <= lever;
         sin_addr1_ff <= sin_addr_in;
         cos_addr1_ff <= cos_addr_in;
         sin_neg1_ff <= sin_quad[1];
         cos_neg1_ff <= cos_quad[1];
      end
   end

   owik_sine_rom #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_rom (
      .clock  (clock),
      .load   (stage.load_s2),
      .addr_a (sin_addr1_ff),
      .addr_b (cos_addr1_ff),
      .data_a (sin_mag),
      .data_b (cos_mag)
   );

   assign turn2_in = 32'(r1_ff) * 32'(lever1_ff);

   always_ff @(posedge clock) begin
      if (stage.load_s2) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         sin_neg2_ff <= sin_neg1_ff;
         cos_neg2_ff <= cos_neg1_ff;
         turn2_ff <= turn2_in;
      end
   end

   always_comb begin
      sin_val = sin_neg2_ff ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      cos_val = cos_neg2_ff ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
      xc3_in = 33'(x2_ff) * 33'(cos_val);
      ys3_in = 33'(y2_ff) * 33'(sin_val);
   end

   always_ff @(posedge clock) begin
      if (stage.load_s3) begin
         xc3_ff <= xc3_in;
         ys3_ff <= ys3_in;
         turn3_ff <= turn2_ff;
      end
   end

   always_comb begin
      sum4 = 35'(xc3_ff) + 35'(ys3_ff) + (35'(turn3_ff) <<< 1) + 35'sd16384;
      drive_in = sum4[32:15];
   end

   always_ff @(posedge clock) begin
      if (stage.load_s4) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule

>>> design/omni_wheel_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics
// Throughput: one command word per cycle; busy stays low outside reset.
// Stages: phase add, sine table read, multiply, rounded sum per wheel lane.
// Reset: synchronous; clears the valid pipeline and loads register defaults.
// The receiver cannot stall; each result word shows for one cycle.
// ----------------------------------------------------------------------------
module omni_wheel_inverse_kinematics #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [15:0]                    req_x_speed,
   input  logic signed [15:0]                    req_y_speed,
   input  logic signed [15:0]                    req_turn_rate,
   input  logic [15:0]                           req_heading,
   output logic                                  rsp_valid,
   output logic signed [17:0]                    rsp_drive_one,
   output logic signed [17:0]                    rsp_drive_two,
   output logic signed [17:0]                    rsp_drive_three,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [owik_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [15:0]                           csr_data
);
   import owik_pkg::*;

   logic               busy_ff;
   logic               accept;
   logic               csr_write;
   logic [15:0]        angle_one_ff;
   logic [15:0]        angle_two_ff;
   logic [15:0]        angle_three_ff;
   logic signed [15:0] lever_one_ff;
   logic signed [15:0] lever_two_ff;
   logic signed [15:0] lever_three_ff;
   logic               v1_ff;
   logic               v2_ff;
   logic               v3_ff;
   logic               v4_ff;
   owik_stage_type     stage;

   assign accept = start && !busy_ff;
   assign csr_write = csr_valid && csr_ready;
   assign busy = busy_ff;
   assign csr_ready = !busy_ff;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_one_ff <= WheelOneAngleReset;
         angle_two_ff <= WheelTwoAngleReset;
         angle_three_ff <= WheelThreeAngleReset;
         lever_one_ff <= WheelOneLeverReset;
         lever_two_ff <= WheelTwoLeverReset;
         lever_three_ff <= WheelThreeLeverReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrWheelOneAngle:   angle_one_ff <= csr_data;
            CsrWheelTwoAngle:   angle_two_ff <= csr_data;
            CsrWheelThreeAngle: angle_three_ff <= csr_data;
            CsrWheelOneLever:   lever_one_ff <= $signed(csr_data);
            CsrWheelTwoLever:   lever_two_ff <= $signed(csr_data);
            CsrWheelThreeLever: lever_three_ff <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      stage.load_s1 = accept;
      stage.load_s2 = v1_ff;
      stage.load_s3 = v2_ff;
      stage.load_s4 = v3_ff;
   end

   owik_wheel_lane #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_lane_one (
      .clock     (clock),
      .stage     (stage),
      .x_speed   (req_x_speed),
      .y_speed   (req_y_speed),
      .turn_rate (req_turn_rate),
      .heading   (req_heading),
      .angle     (angle_one_ff),
      .lever     (lever_one_ff),
      .drive     (rsp_drive_one)
   );

   owik_wheel_lane #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_lane_two (
      .clock     (clock),
      .stage     (stage),
      .x_speed   (req_x_speed),
      .y_speed   (req_y_speed),
      .turn_rate (req_turn_rate),
      .heading   (req_heading),
      .angle     (angle_two_ff),
      .lever     (lever_two_ff),
      .drive     (rsp_drive_two)
   );

   owik_wheel_lane #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_lane_three (
      .clock     (clock),
      .stage     (stage),
      .x_speed   (req_x_speed),
      .y_speed   (req_y_speed),
      .turn_rate (req_turn_rate),
      .heading   (req_heading),
      .angle     (angle_three_ff),
      .lever     (lever_three_ff),
      .drive     (rsp_drive_three)
   );

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted word did not produce a result after 4 cycles");

   a_not_busy : assert property (@(posedge clock)
      !reset |=> !busy)
      else $error("busy high outside reset");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_one <= 18'sd111877 && rsp_drive_one >= -18'sd111877
                  && rsp_drive_two <= 18'sd111877 && rsp_drive_two >= -18'sd111877
                  && rsp_drive_three <= 18'sd111877 && rsp_drive_three >= -18'sd111877))
      else $error("drive result out of range");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for omni_wheel_inverse_kinematics. Velocity command words go in
// through the start/busy port, wheel geometry goes in through the register
// port, and every drive word that comes out is compared against wheel speeds
// computed here from a quarter-wave sine table built the same way in fixed
// point. Directed corners come first, then random commands under three
// sender idle rates and several wheel geometries.
// ----------------------------------------------------------------------------
module tb;
   import owik_pkg::*;

   localparam int SineBits = 10;
   localparam int SineSize = 1 << SineBits;
   localparam int QuietLimit = 2000;
   localparam int FlushCycles = 8;
   localparam logic [63:0] QuarterTurnQ30 = 64'd1686629713;
   localparam logic [CsrIndexWidth-1:0] CsrUnusedLow  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CsrUnusedHigh = 3'd7;

   typedef struct {
      logic signed [17:0] one;
      logic signed [17:0] two;
      logic signed [17:0] three;
   } wheel_drives_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [15:0]       req_x_speed = '0;
   logic signed [15:0]       req_y_speed = '0;
   logic signed [15:0]       req_turn_rate = '0;
   logic [15:0]              req_heading = '0;
   logic                     rsp_valid;
   logic signed [17:0]       rsp_drive_one;
   logic signed [17:0]       rsp_drive_two;
   logic signed [17:0]       rsp_drive_three;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [15:0]              csr_data = '0;

   int                 quarter_sine [0:SineSize];
   logic [15:0]        wheel_angle [3];
   logic signed [15:0] wheel_lever [3];
   wheel_drives_type   pending_drives [$];
   int                 mismatches = 0;
   int                 quiet_cycles = 0;
   int                 idle_pct = 0;

   omni_wheel_inverse_kinematics #(
      .SINE_TABLE_BITS(SineBits)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_speed    (req_x_speed),
      .req_y_speed    (req_y_speed),
      .req_turn_rate  (req_turn_rate),
      .req_heading    (req_heading),
      .rsp_valid      (rsp_valid),
      .rsp_drive_one  (rsp_drive_one),
      .rsp_drive_two  (rsp_drive_two),
      .rsp_drive_three(rsp_drive_three),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // quarter-wave table, Q15, Taylor series in Q30
   initial begin
      longint unsigned t;
      longint unsigned t2;
      longint unsigned term;
      longint          acc;
      for (int i = 0; i <= SineSize; i++) begin
         t = (QuarterTurnQ30 * longint'(i) + (SineSize >> 1)) >> SineBits;
         t2 = (t * t) >> 30;
         term = t;
         acc = longint'(t);
         for (int k = 1; k <= 6; k++) begin
            term = (term * t2) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) begin
            acc = 0;
         end
         acc = (acc + 16384) >>> 15;
         quarter_sine[i] = (acc > 32768) ? 32768 : int'(acc);
      end
   end

   function automatic int sine_q15(input logic [15:0] phase);
      logic [15:0] p;
      logic [1:0]  quad;
      int          idx;
      int          v;
      p = phase >> (14 - SineBits);
      quad = p[SineBits+1 -: 2];
      idx = int'(p[SineBits-1:0]);
      v = quad[0] ? quarter_sine[SineSize - idx] : quarter_sine[idx];
      return quad[1] ? -v : v;
   endfunction

   function automatic logic signed [17:0] wheel_drive(input logic signed [15:0] x,
                                                      input logic signed [15:0] y,
                                                      input logic signed [15:0] r,
                                                      input logic [15:0] heading,
                                                      input logic [15:0] angle,
                                                      input logic signed [15:0] lever);
      logic [15:0] phase;
      longint      acc;
      phase = angle + heading;
      acc = longint'(x) * sine_q15(phase + 16'd16384) + longint'(y) * sine_q15(phase)
            + 2 * longint'(r) * longint'(lever);
      acc = (acc + 16384) >>> 15;
      return acc[17:0];
   endfunction

   function automatic wheel_drives_type command_drives(input logic signed [15:0] x,
                                                       input logic signed [15:0] y,
                                                       input logic signed [15:0] r,
                                                       input logic [15:0] heading);
      wheel_drives_type d;
      d.one   = wheel_drive(x, y, r, heading, wheel_angle[0], wheel_lever[0]);
      d.two   = wheel_drive(x, y, r, heading, wheel_angle[1], wheel_lever[1]);
      d.three = wheel_drive(x, y, r, heading, wheel_angle[2], wheel_lever[2]);
      return d;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // track geometry, predict accepted commands, check drive words
   always @(posedge clock) begin
      wheel_drives_type want;
      if (reset) begin
         wheel_angle[0] <= WheelOneAngleReset;
         wheel_angle[1] <= WheelTwoAngleReset;
         wheel_angle[2] <= WheelThreeAngleReset;
         wheel_lever[0] <= WheelOneLeverReset;
         wheel_lever[1] <= WheelTwoLeverReset;
         wheel_lever[2] <= WheelThreeLeverReset;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_drives.size() == 0) begin
               report_mismatch("drive word with no command pending");
            end else begin
               want = pending_drives.pop_front();
               if (rsp_drive_one !== want.one) begin
                  report_mismatch($sformatf("drive_one got %0d expected %0d",
                                            rsp_drive_one, want.one));
               end
               if (rsp_drive_two !== want.two) begin
                  report_mismatch($sformatf("drive_two got %0d expected %0d",
                                            rsp_drive_two, want.two));
               end
               if (rsp_drive_three !== want.three) begin
                  report_mismatch($sformatf("drive_three got %0d expected %0d",
                                            rsp_drive_three, want.three));
               end
            end
         end
         if (start && !busy) begin
            pending_drives.push_back(command_drives(req_x_speed, req_y_speed,
                                                    req_turn_rate, req_heading));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrWheelOneAngle: begin
                  wheel_angle[0] <= csr_data;
               end
               CsrWheelTwoAngle: begin
                  wheel_angle[1] <= csr_data;
               end
               CsrWheelThreeAngle: begin
                  wheel_angle[2] <= csr_data;
               end
               CsrWheelOneLever: begin
                  wheel_lever[0] <= csr_data;
               end
               CsrWheelTwoLever: begin
                  wheel_lever[1] <= csr_data;
               end
               CsrWheelThreeLever: begin
                  wheel_lever[2] <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_command(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] r, input logic [15:0] heading);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) begin
         gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_x_speed   <= x;
      req_y_speed   <= y;
      req_turn_rate <= r;
      req_heading   <= heading;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // hold off until every drive word is back
   task automatic drain_results();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_drives.size() != 0);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic load_wheels(input logic [15:0] a1, input logic [15:0] a2,
                              input logic [15:0] a3, input logic [15:0] l1,
                              input logic [15:0] l2, input logic [15:0] l3);
      drain_results();
      write_register(CsrWheelOneAngle, a1);
      write_register(CsrWheelTwoAngle, a2);
      write_register(CsrWheelThreeAngle, a3);
      write_register(CsrWheelOneLever, l1);
      write_register(CsrWheelTwoLever, l2);
      write_register(CsrWheelThreeLever, l3);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_heading();
      if ($urandom_range(7) == 0) begin
         return (16'($urandom_range(3)) << 14) + 16'($urandom_range(16)) - 16'd8;
      end
      return 16'($urandom);
   endfunction

   task automatic randomize_wheels();
      load_wheels(pick_heading(), pick_heading(), pick_heading(),
                  pick_word(), pick_word(), pick_word());
   endtask

   task automatic run_random(input int count, input int pct, input bit hold_midway);
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         if (hold_midway && n == count / 2) begin
            drain_results();
         end
         send_command(pick_word(), pick_word(), pick_word(), pick_heading());
      end
   endtask

   task automatic test_reset_geometry();
      idle_pct = 20;
      send_command(0, 0, 0, 0);
      send_command(32767, 32767, 32767, 0);
      send_command(-32768, -32768, -32768, 0);
      send_command(32767, -32768, 32767, 16384);
      send_command(-32768, 32767, -32768, 32768);
      send_command(1, -1, 1, 49152);
      send_command(32767, 0, 0, 65535);
      send_command(0, 32767, 0, 15);
      send_command(0, -32768, 0, 16);
      send_command(0, 0, 32767, 12345);
      send_command(-1, -1, -1, 16383);
   endtask

   task automatic test_geometry_extremes();
      drain_results();
      // unused indexes must leave the geometry alone
      write_register(CsrUnusedLow, 16'hFFFF);
      write_register(CsrUnusedHigh, 16'h5A5A);
      load_wheels(16'd0, 16'd65535, 16'd32768, 16'h8000, 16'h7FFF, 16'h0000);
      send_command(32767, 32767, 32767, 0);
      send_command(-32768, -32768, -32768, 65535);
      send_command(32767, -32768, -32768, 16384);
      send_command(-32768, 32767, 32767, 1);
      load_wheels(16'd65535, 16'd0, 16'd49152, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_command(32767, 32767, 32767, 65535);
      send_command(-32768, -32768, 32767, 32767);
      send_command(0, 0, -32768, 0);
      // half an LSB on the turn term rounds up
      load_wheels(16'd0, 16'd16384, 16'd32768, 16'd8192, 16'hE000, 16'd1);
      send_command(0, 0, 1, 0);
      send_command(0, 0, -1, 0);
      send_command(0, 0, 3, 0);
      send_command(0, 0, -3, 0);
   endtask

   task automatic test_light_idle();
      load_wheels(WheelOneAngleReset, WheelTwoAngleReset, WheelThreeAngleReset,
                  WheelOneLeverReset, WheelTwoLeverReset, WheelThreeLeverReset);
      run_random(600, 20, 1'b0);
   endtask

   task automatic test_heavy_idle();
      randomize_wheels();
      run_random(600, 76, 1'b1);
   endtask

   task automatic test_back_to_back();
      for (int s = 0; s < 5; s++) begin
         randomize_wheels();
         run_random(125, 0, 1'b0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_geometry_extremes();
      test_light_idle();
      test_heavy_idle();
      test_back_to_back();
      drain_results();
      repeat (FlushCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
design/owik_pkg.sv
design/owik_sine_rom.sv
design/owik_wheel_lane.sv
design/omni_wheel_inverse_kinematics.sv
dv/tb.sv
